FILE: rtl/kpg_pkg.sv
// Package: shared types, constants and helper functions of the keyed PCG32 generator.
`default_nettype none
package kpg_pkg;

    localparam int unsigned CATEGORY_COUNT   = 10;
    localparam int unsigned NAMED_CATEGORIES = 10;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT  = 32'd16777619;
    localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
    localparam logic [31:0] TAG_MIX   = 32'h9e3779b9;

    typedef enum logic [1:0] {
        ACT_OPEN    = 2'd0,
        ACT_RAW     = 2'd1,
        ACT_BOUNDED = 2'd2,
        ACT_UNIT    = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_MUL,
        ST_SEED,
        ST_MUL_LL,
        ST_MUL_HL,
        ST_MUL_LH,
        ST_MUL_FIN,
        ST_FLOOR_DIV,
        ST_CHECK,
        ST_MOD_DIV,
        ST_DONE
    } t_state;

    // FNV-1a over an ASCII name, first character in the highest used byte.
    // Evaluated at elaboration only.
    function automatic logic [31:0] fnv1a(input logic [63:0] txt, input int unsigned len);
        logic [31:0] h;
        logic [63:0] p;
        h = FNV_BASIS;
        for (int unsigned i = 0; i < 8; i++) begin
            if (i < len) begin
                p = {32'd0, h ^ {24'd0, txt[8*(len-1-i) +: 8]}} * {32'd0, FNV_MULT};
                h = p[31:0];
            end
        end
        return h;
    endfunction

    localparam logic [31:0] CAT_HASH [16] = '{
        fnv1a("ai", 2),       fnv1a("money", 5),    fnv1a("unlocks", 7),
        fnv1a("tracks", 6),   fnv1a("pods", 4),     fnv1a("favorite", 8),
        fnv1a("mirror", 6),   fnv1a("laps", 4),     fnv1a("shop", 4),
        fnv1a("winnings", 8), 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    function automatic logic cat_ok(input logic [3:0] c);
        return (32'(c) < CATEGORY_COUNT) && (32'(c) < NAMED_CATEGORIES);
    endfunction

    // XSH-RR output permutation of the previous LCG state.
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] x;
        logic [31:0] mixed;
        logic [63:0] dbl;
        logic [63:0] rot;
        x     = (s >> 18) ^ s;
        mixed = x[58:27];
        dbl   = {mixed, mixed};
        rot   = dbl >> s[63:59];
        return rot[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/kpg_if.sv
// Interfaces: request, result and configuration channels of the keyed PCG32 generator.
`default_nettype none
interface kpg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  category;
    logic [31:0] stream_key;
    logic [31:0] bound;

    modport source (output valid, action, category, stream_key, bound, input ready);
    modport sink   (input valid, action, category, stream_key, bound, output ready);
endinterface

interface kpg_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        stream_valid;

    modport source (output valid, value, stream_valid, input ready);
    modport sink   (input valid, value, stream_valid, output ready);
endinterface

interface kpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/keyed_pcg32_stream_generator_top.sv
// Top level: keyed PCG32 (XSH-RR) stream generator with a shared multiplier and a serial divider.
//
// Usage
//  - i_in: one request transaction = action, category, stream_key, bound.
//    Actions: open stream, raw draw, bounded draw, unit fraction (0.24) draw.
//  - o_out: exactly one result transaction per request: value, stream_valid.
//  - i_cfg: writes profile_seed; always ready, write only while idle.
//  - Path from request to result (sequencer states in order):
//      raw / unit draw: LCG step, ST_DONE; open: ST_KEY_MUL, ST_SEED, LCG step, ST_DONE;
//      open with bad category, or bounded with zero bound or zero stream: ST_DONE;
//      bounded draw: ST_FLOOR_DIV, then LCG step and ST_CHECK per candidate, ST_MOD_DIV, ST_DONE.
//    The LCG step (ST_MUL_LL .. ST_MUL_FIN) is the 64x64 multiply done as three
//    32x32 partial products on one registered multiplier; the 1-bit-per-cycle
//    remainder unit is used twice per bounded draw (rejection floor, then final modulo).
//  - One request at a time: i_in.ready is high only while the sequencer idles,
//    so a new request is taken only once the previous one has left ST_DONE.
//    A finished result sits in the output register; the next request is taken
//    while it waits, and that one's result holds in ST_DONE until the slot frees.
//  - Reset (i_rst_n low, synchronous): profile_seed, LCG state and increment
//    clear to zero, no result pending.
`default_nettype none
module keyed_pcg32_stream_generator_top
    import kpg_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    kpg_in_if.sink     i_in,
    kpg_out_if.source  o_out,
    kpg_cfg_if.sink    i_cfg
);

    // Sequencer
    t_state      r_state, n_state;

    // Architectural state
    logic [31:0] r_seed;
    logic [63:0] r_lcg_state, n_lcg_state;
    logic [63:0] r_lcg_inc, n_lcg_inc;

    // Captured request
    t_action     r_action, n_action;
    logic [3:0]  r_cat, n_cat;
    logic [31:0] r_key, n_key;
    logic [31:0] r_bound, n_bound;

    // Shared multiplier and LCG accumulator
    logic [31:0] w_mul_x, w_mul_y;
    logic [63:0] r_prod;
    logic [63:0] r_acc, n_acc;

    // Draw, rejection floor and result
    logic [31:0] r_draw, n_draw;
    logic [31:0] r_floor, n_floor;
    logic [31:0] r_res, n_res;
    logic        r_res_sv, n_res_sv;

    // Serial remainder unit
    logic [31:0] r_dvd, n_dvd;
    logic [31:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] w_div_t, w_div_diff;
    logic        w_div_ge;
    logic [31:0] w_div_rem;
    logic        w_div_last;

    // Output register
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_value, n_out_value;
    logic        r_out_sv, n_out_sv;

    logic        w_in_fire;
    logic        w_out_free;
    logic        w_bnd_skip;
    logic [31:0] w_tag;

    assign i_in.ready         = (r_state == ST_IDLE);
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_value;
    assign o_out.stream_valid = r_out_sv;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    // zero bound or even increment (zero stream): answer 0 without stepping
    assign w_bnd_skip = (i_in.bound == 32'd0) || !r_lcg_inc[0];
    assign w_tag      = CAT_HASH[r_cat] ^ r_prod[31:0];

    // restoring remainder step, one dividend bit per cycle
    assign w_div_t    = {r_rem, r_dvd[31]};
    assign w_div_diff = w_div_t - {1'b0, r_bound};
    assign w_div_ge   = (w_div_t >= {1'b0, r_bound});
    assign w_div_rem  = w_div_ge ? w_div_diff[31:0] : w_div_t[31:0];
    assign w_div_last = (r_cnt == '1);

    // Multiplier operand select: key mix, then low*low, high*low, low*high.
    always_comb begin
        unique case (r_state)
            ST_KEY_MUL: begin
                w_mul_x = r_key;
                w_mul_y = TAG_MIX;
            end
            ST_MUL_LL: begin
                w_mul_x = r_lcg_state[31:0];
                w_mul_y = LCG_MULT[31:0];
            end
            ST_MUL_HL: begin
                w_mul_x = r_lcg_state[63:32];
                w_mul_y = LCG_MULT[31:0];
            end
            ST_MUL_LH: begin
                w_mul_x = r_lcg_state[31:0];
                w_mul_y = LCG_MULT[63:32];
            end
            default: begin
                w_mul_x = 32'd0;
                w_mul_y = 32'd0;
            end
        endcase
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    unique case (t_action'(i_in.action))
                        ACT_OPEN:    n_state = cat_ok(i_in.category) ? ST_KEY_MUL : ST_DONE;
                        ACT_RAW:     n_state = ST_MUL_LL;
                        ACT_UNIT:    n_state = ST_MUL_LL;
                        ACT_BOUNDED: n_state = w_bnd_skip ? ST_DONE : ST_FLOOR_DIV;
                    endcase
                end
            end
            ST_KEY_MUL:   n_state = ST_SEED;
            ST_SEED:      n_state = ST_MUL_LL;
            ST_MUL_LL:    n_state = ST_MUL_HL;
            ST_MUL_HL:    n_state = ST_MUL_LH;
            ST_MUL_LH:    n_state = ST_MUL_FIN;
            ST_MUL_FIN:   n_state = (r_action == ACT_BOUNDED) ? ST_CHECK : ST_DONE;
            ST_FLOOR_DIV: if (w_div_last) n_state = ST_MUL_LL;
            ST_CHECK:     n_state = (r_draw >= r_floor) ? ST_MOD_DIV : ST_MUL_LL;
            ST_MOD_DIV:   if (w_div_last) n_state = ST_DONE;
            ST_DONE:      if (w_out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // Datapath and output logic
    always_comb begin
        n_lcg_state = r_lcg_state;
        n_lcg_inc   = r_lcg_inc;
        n_action    = r_action;
        n_cat       = r_cat;
        n_key       = r_key;
        n_bound     = r_bound;
        n_acc       = r_acc;
        n_draw      = r_draw;
        n_floor     = r_floor;
        n_res       = r_res;
        n_res_sv    = r_res_sv;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_value = r_out_value;
        n_out_sv    = r_out_sv;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_action = t_action'(i_in.action);
                    n_cat    = i_in.category;
                    n_key    = i_in.stream_key;
                    n_bound  = i_in.bound;
                    n_res    = 32'd0;
                    n_res_sv = 1'b0;
                    n_cnt    = '0;
                    n_rem    = 32'd0;
                    n_dvd    = 32'd0 - i_in.bound;
                    n_draw   = xsh_rr(r_lcg_state);
                    if (t_action'(i_in.action) == ACT_OPEN && !cat_ok(i_in.category)) begin
                        n_lcg_state = 64'd0;
                        n_lcg_inc   = 64'd0;
                    end
                end
            end
            ST_SEED: begin
                // inc = (tag:seed) << 1 | 1; first step leaves state = inc, then += start
                n_lcg_inc   = {w_tag[30:0], r_seed, 1'b1};
                n_lcg_state = {r_seed, w_tag} + {w_tag[30:0], r_seed, 1'b1};
                n_res_sv    = 1'b1;
            end
            ST_MUL_HL: n_acc = r_prod + r_lcg_inc;
            ST_MUL_LH: n_acc = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
            ST_MUL_FIN: begin
                n_lcg_state = {r_acc[63:32] + r_prod[31:0], r_acc[31:0]};
                if (r_action == ACT_RAW) begin
                    n_res = r_draw;
                end else if (r_action == ACT_UNIT) begin
                    n_res = {8'd0, r_draw[31:8]};
                end
            end
            ST_FLOOR_DIV: begin
                n_rem = w_div_rem;
                n_dvd = {r_dvd[30:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (w_div_last) begin
                    n_floor = w_div_rem;
                    n_draw  = xsh_rr(r_lcg_state);
                end
            end
            ST_CHECK: begin
                if (r_draw >= r_floor) begin
                    n_dvd = r_draw;
                    n_rem = 32'd0;
                    n_cnt = '0;
                end else begin
                    n_draw = xsh_rr(r_lcg_state);
                end
            end
            ST_MOD_DIV: begin
                n_rem = w_div_rem;
                n_dvd = {r_dvd[30:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (w_div_last) begin
                    n_res = w_div_rem;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                    n_out_sv    = r_res_sv;
                end
            end
            default: ;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= 32'd0;
            r_lcg_state <= 64'd0;
            r_lcg_inc   <= 64'd0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_lcg_state <= n_lcg_state;
            r_lcg_inc   <= n_lcg_inc;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            if (i_cfg.valid && i_cfg.ready) begin
                r_seed <= i_cfg.data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod      <= {32'd0, w_mul_x} * {32'd0, w_mul_y};
        r_acc       <= n_acc;
        r_action    <= n_action;
        r_cat       <= n_cat;
        r_key       <= n_key;
        r_bound     <= n_bound;
        r_draw      <= n_draw;
        r_floor     <= n_floor;
        r_res       <= n_res;
        r_res_sv    <= n_res_sv;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_out_value <= n_out_value;
        r_out_sv    <= n_out_sv;
    end

    // Assertions
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result appeared outside ST_DONE");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLOOR_DIV || r_state == ST_MOD_DIV) |-> (r_bound != 32'd0))
        else $error("remainder unit running with zero divisor");

    a_bounded_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD_DIV && w_div_last) |=> (r_res < r_bound))
        else $error("bounded draw result not below bound");

    a_open_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sv) |-> (r_out_value == 32'd0))
        else $error("open result carries nonzero value");

endmodule
`default_nettype wire
